[sv/mvcr_pkg.sv]
// Shared types, codes and palette tables of the column renderer.
`timescale 1ns / 1ps

package mvcr_pkg;

    localparam int COLUMNS      = 38;
    localparam int SAMPLE_COUNT = 75;
    localparam int ROWS         = 5;
    localparam int SA_AW        = $clog2(SAMPLE_COUNT);

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_RENDER = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_DISPLAY_MODE = 2'd0;
    localparam logic [1:0] REG_BAR_LAYOUT   = 2'd1;
    localparam logic [1:0] REG_SMOOTH_METER = 2'd2;
    localparam logic [1:0] REG_SCOPE_STYLE  = 2'd3;

    // Display modes.
    localparam logic [1:0] MODE_ANALYZER = 2'd0;
    localparam logic [1:0] MODE_VU       = 2'd1;
    localparam logic [1:0] MODE_SCOPE    = 2'd2;
    localparam logic [1:0] MODE_OFF      = 2'd3;

    // Scope drawing styles.
    localparam logic [1:0] STYLE_DOT  = 2'd0;
    localparam logic [1:0] STYLE_LINE = 2'd1;

    localparam logic [4:0] ANALYZER_PAL [ROWS] = '{5'd14, 5'd11, 5'd8, 5'd5, 5'd2};
    localparam logic [4:0] SCOPE_PAL    [ROWS] = '{5'd20, 5'd19, 5'd18, 5'd19, 5'd20};
    localparam logic [4:0] VU_PAL       [8]    =
        '{5'd16, 5'd14, 5'd12, 5'd10, 5'd8, 5'd6, 5'd4, 5'd2};
    localparam logic [2:0] SCOPE_HEIGHT [17]   =
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd2,
          3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4};

    typedef logic [4:0] t_color;
    typedef t_color [ROWS-1:0] t_colors;

    typedef struct packed {
        logic [1:0] display_mode;
        logic       bar_layout;
        logic       smooth_meter;
        logic [1:0] scope_style;
    } t_cfg;

    typedef struct packed {
        logic             wr_en;
        logic             clr;
        logic             rd_en;
        logic [SA_AW-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic [SA_AW-1:0] rd_addr_a;
        logic [SA_AW-1:0] rd_addr_b;
    } t_store_cmd;

    typedef struct packed {
        logic [7:0] level_a;
        logic [7:0] level_b;
        logic       has_data;
    } t_store_rsp;

endpackage

[sv/mini_vis_column_renderer_top.sv]
// Top level of the small visualizer column renderer.
// The block accepts one transaction per clock cycle while o_in_ready is high: a sample
// write, a store clear or a column render. The accepting edge of a render transaction
// registers the read of the 75-entry sample store; the five palette indices are then
// computed combinationally and loaded into the output register once it is free.
// While an untaken result sits in the output register and another render waits behind
// it, the input is held off until the output side takes the result. Writes and clears
// produce no result. Clearing takes effect at once through per-entry valid bits, so
// there is no clearing pass after reset. Configuration is written through the plain write
// port, by the user only while no render is in flight; the block does not enforce it.
`timescale 1ns / 1ps

module mini_vis_column_renderer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [1:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_op,
    input  logic [6:0] i_sample_index,
    input  logic [7:0] i_sample_value,
    input  logic [5:0] i_column,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [5:0] o_out_column,
    output logic [4:0] o_row0_color,
    output logic [4:0] o_row1_color,
    output logic [4:0] o_row2_color,
    output logic [4:0] o_row3_color,
    output logic [4:0] o_row4_color
);
    import mvcr_pkg::*;

    t_cfg        r_cfg;
    t_store_cmd  cmd;
    t_store_rsp  rsp;
    t_colors     colors;
    t_colors     r_out_colors;
    logic [5:0]  r_out_column;
    logic        r_out_vld;
    logic        r_s1_vld;
    logic [5:0]  r_s1_column;
    logic        out_free;
    logic        s1_adv;
    logic        accept;
    logic        is_render;
    logic [11:0] div3_prod;
    logic [SA_AW-1:0] scope_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DISPLAY_MODE: r_cfg.display_mode <= i_cfg_data;
                REG_BAR_LAYOUT:   r_cfg.bar_layout   <= i_cfg_data[0];
                REG_SMOOTH_METER: r_cfg.smooth_meter <= i_cfg_data[0];
                REG_SCOPE_STYLE:  r_cfg.scope_style  <= i_cfg_data;
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    assign out_free   = !r_out_vld || i_out_ready;
    assign s1_adv     = r_s1_vld && out_free;
    assign o_in_ready = !r_s1_vld || out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign is_render  = accept && (i_op == OP_RENDER);

    assign div3_prod  = 12'(i_column) * 12'd43;
    assign scope_addr = {i_column, 1'b0};

    // Read addresses depend on the mode: one analyzer bin, the two VU
    // channels, or the scope sample of this column and of the next one.
    always_comb begin
        cmd.wr_en   = accept && (i_op == OP_WRITE) &&
                      (i_sample_index < SA_AW'(SAMPLE_COUNT));
        cmd.clr     = accept && (i_op == OP_CLEAR);
        cmd.rd_en   = is_render;
        cmd.wr_addr = i_sample_index;
        cmd.wr_data = i_sample_value;
        case (r_cfg.display_mode)
            MODE_ANALYZER: begin
                cmd.rd_addr_a = r_cfg.bar_layout ? SA_AW'(div3_prod[11:7])
                                                 : SA_AW'(i_column);
                cmd.rd_addr_b = cmd.rd_addr_a;
            end
            MODE_VU: begin
                cmd.rd_addr_a = SA_AW'(0);
                cmd.rd_addr_b = SA_AW'(1);
            end
            default: begin
                cmd.rd_addr_a = scope_addr;
                cmd.rd_addr_b = scope_addr + SA_AW'(2);
            end
        endcase
    end

    mvcr_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (is_render) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_render) begin
            r_s1_column <= i_column;
        end
    end

    mvcr_pixel u_pixel (
        .i_cfg    (r_cfg),
        .i_column (r_s1_column),
        .i_rsp    (rsp),
        .o_colors (colors)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_column <= r_s1_column;
            r_out_colors <= colors;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_out_column = r_out_column;
    assign o_row0_color = r_out_colors[0];
    assign o_row1_color = r_out_colors[1];
    assign o_row2_color = r_out_colors[2];
    assign o_row3_color = r_out_colors[3];
    assign o_row4_color = r_out_colors[4];

endmodule

[sv/mvcr_store.sv]
// Sample store with per-entry valid bits, active flag and registered reads.
`timescale 1ns / 1ps

module mvcr_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mvcr_pkg::t_store_cmd i_cmd,
    output mvcr_pkg::t_store_rsp o_rsp
);
    import mvcr_pkg::*;

    logic [7:0]              r_mem [SAMPLE_COUNT];
    logic [SAMPLE_COUNT-1:0] r_valid;
    logic [SAMPLE_COUNT-1:0] n_valid;
    logic                    r_has_data;
    logic                    n_has_data;
    logic [7:0]              r_rd_a;
    logic [7:0]              r_rd_b;
    logic                    r_ok_a;
    logic                    r_ok_b;
    logic                    r_has_q;

    // A cleared or never written entry reads as zero through its valid bit.
    always_comb begin
        n_valid    = r_valid;
        n_has_data = r_has_data;
        if (i_cmd.clr) begin
            n_valid    = '0;
            n_has_data = 1'b0;
        end else if (i_cmd.wr_en) begin
            n_valid[i_cmd.wr_addr] = 1'b1;
            n_has_data             = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_has_data <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_has_data <= n_has_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_a  <= r_mem[i_cmd.rd_addr_a];
            r_rd_b  <= r_mem[i_cmd.rd_addr_b];
            r_ok_a  <= (i_cmd.rd_addr_a < SA_AW'(SAMPLE_COUNT)) && r_valid[i_cmd.rd_addr_a];
            r_ok_b  <= (i_cmd.rd_addr_b < SA_AW'(SAMPLE_COUNT)) && r_valid[i_cmd.rd_addr_b];
            r_has_q <= r_has_data;
        end
    end

    assign o_rsp.level_a  = r_ok_a ? r_rd_a : 8'd0;
    assign o_rsp.level_b  = r_ok_b ? r_rd_b : 8'd0;
    assign o_rsp.has_data = r_has_q;

endmodule

[sv/mvcr_pixel.sv]
// Palette index logic for the five rows of one display column.
`timescale 1ns / 1ps

module mvcr_pixel (
    input  mvcr_pkg::t_cfg       i_cfg,
    input  logic [5:0]           i_column,
    input  mvcr_pkg::t_store_rsp i_rsp,
    output mvcr_pkg::t_colors    o_colors
);
    import mvcr_pkg::*;

    logic [11:0] div3_prod;
    logic [4:0]  q3;
    logic [5:0]  m3;
    logic [1:0]  rem3;
    logic [2:0]  an_h;
    logic [9:0]  div5_prod;
    logic [3:0]  seg;
    logic [5:0]  m5;
    logic [10:0] seg_thr;
    logic [10:0] grad_prod;
    logic [4:0]  grad;
    logic        vu_lit_a;
    logic        vu_lit_b;
    logic [4:0]  vu_color;
    logic [4:0]  sidx_a;
    logic [4:0]  sidx_b;
    logic [2:0]  sh_a;
    logic [2:0]  sh_b;
    logic [2:0]  sc_lo;
    logic [2:0]  sc_hi;
    t_colors     colors;

    // Division by 3, 5 and 19 through reciprocal multiplies, exact for 6-bit columns.
    assign div3_prod = 12'(i_column) * 12'd43;
    assign q3        = div3_prod[11:7];
    assign m3        = i_column - 6'({1'b0, q3} * 6'd3);
    assign rem3      = m3[1:0];
    assign an_h      = (i_rsp.level_a > 8'd5) ? 3'd5 : i_rsp.level_a[2:0];

    assign div5_prod = 10'(i_column) * 10'd13;
    assign seg       = div5_prod[9:6];
    assign m5        = i_column - 6'({2'b00, seg} * 6'd5);
    // seg < (8*d + 19) / 38 holds exactly when 38*seg + 19 <= 8*d.
    assign seg_thr   = 11'(seg) * 11'd38 + 11'd19;
    assign grad_prod = 11'(i_column) * 11'd27;
    assign grad      = grad_prod[10:6];

    always_comb begin
        if (i_cfg.smooth_meter) begin
            vu_lit_a = {2'b00, i_column} < i_rsp.level_a;
            vu_lit_b = {2'b00, i_column} < i_rsp.level_b;
            vu_color = 5'd17 - grad;
        end else begin
            vu_lit_a = (m5 < 6'd3) && (seg_thr <= {i_rsp.level_a, 3'b000});
            vu_lit_b = (m5 < 6'd3) && (seg_thr <= {i_rsp.level_b, 3'b000});
            vu_color = VU_PAL[seg[2:0]];
        end
    end

    assign sidx_a = (i_rsp.level_a > 8'd16) ? 5'd16 : i_rsp.level_a[4:0];
    assign sidx_b = (i_rsp.level_b > 8'd16) ? 5'd16 : i_rsp.level_b[4:0];
    assign sh_a   = SCOPE_HEIGHT[sidx_a];
    assign sh_b   = SCOPE_HEIGHT[sidx_b];

    always_comb begin
        sc_lo = sh_a;
        sc_hi = sh_a;
        case (i_cfg.scope_style)
            STYLE_DOT: begin
                sc_lo = sh_a;
            end
            STYLE_LINE: begin
                // The last column has no right neighbor and draws as a dot.
                if (i_column < 6'(COLUMNS - 1)) begin
                    if (sh_a < sh_b) begin
                        sc_hi = sh_b - 3'd1;
                    end else if (sh_a > sh_b) begin
                        sc_lo = sh_b + 3'd1;
                    end
                end
            end
            default: begin
                if (sh_a < 3'd2) begin
                    sc_hi = 3'd2;
                end else begin
                    sc_lo = 3'd2;
                end
            end
        endcase
    end

    always_comb begin
        colors = '0;
        if (i_column < 6'(COLUMNS)) begin
            case (i_cfg.display_mode)
                MODE_ANALYZER: begin
                    if (!(i_cfg.bar_layout && rem3 == 2'd2)) begin
                        for (int y = 0; y < ROWS; y++) begin
                            if (3'(ROWS - 1 - y) < an_h) begin
                                colors[y] = ANALYZER_PAL[ROWS - 1 - y];
                            end
                        end
                    end
                end
                MODE_VU: begin
                    // The upper two rows show the first sample, the lower two the second.
                    for (int y = 0; y < ROWS; y++) begin
                        if ((y < 2 && vu_lit_a) || (y > 2 && vu_lit_b)) begin
                            colors[y] = vu_color;
                        end
                    end
                end
                MODE_SCOPE: begin
                    if (i_rsp.has_data) begin
                        for (int y = 0; y < ROWS; y++) begin
                            if (3'(y) >= sc_lo && 3'(y) <= sc_hi) begin
                                colors[y] = SCOPE_PAL[y];
                            end
                        end
                    end
                end
                default: begin
                    colors = '0;
                end
            endcase
        end
    end

    assign o_colors = colors;

endmodule

[sv/mvcr_checker.sv]
// Port-level checks of the column renderer, bound to its top level.
`timescale 1ns / 1ps

module mvcr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [5:0] o_out_column,
    input logic [4:0] o_row0_color,
    input logic [4:0] o_row1_color,
    input logic [4:0] o_row2_color,
    input logic [4:0] o_row3_color,
    input logic [4:0] o_row4_color
);
    import mvcr_pkg::*;

    // A result that is not taken stays, with its column and rows 0, 2 and 4 unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_column) &&
        $stable(o_row0_color) && $stable(o_row2_color) && $stable(o_row4_color))
        else $error("result transaction changed while stalled");

    // Reset empties the pipeline: no result and room for a new transaction.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

    // A column beyond the display is all background.
    a_blank_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_column >= 6'(COLUMNS) |->
        o_row0_color == 5'd0 && o_row1_color == 5'd0 && o_row2_color == 5'd0 &&
        o_row3_color == 5'd0 && o_row4_color == 5'd0)
        else $error("column beyond display is not blank");

    // Every palette index stays inside the palette.
    a_palette_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_row0_color <= 5'd23 && o_row1_color <= 5'd23 &&
        o_row2_color <= 5'd23 && o_row3_color <= 5'd23 && o_row4_color <= 5'd23)
        else $error("palette index out of range");

endmodule

bind mini_vis_column_renderer_top mvcr_checker u_mvcr_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the column renderer: stimulus, predictor and result checks.
`timescale 1ns / 1ps

import mvcr_pkg::*;

// Codes that the package leaves unnamed.
localparam logic [1:0] OP_SPARE    = 2'd3;
localparam logic [1:0] STYLE_SPARE = 2'd3;

// Palette and height tables of the picture, kept apart from the design's own copies.
localparam logic [4:0] BAR_SHADES   [5] = '{5'd14, 5'd11, 5'd8, 5'd5, 5'd2};
localparam logic [4:0] TRACE_SHADES [5] = '{5'd20, 5'd19, 5'd18, 5'd19, 5'd20};
localparam logic [4:0] METER_SHADES [8] =
    '{5'd16, 5'd14, 5'd12, 5'd10, 5'd8, 5'd6, 5'd4, 5'd2};
localparam logic [2:0] TRACE_ROW_OF_LEVEL [17] =
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd2,
      3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4};

typedef struct packed {
    logic [5:0] column;
    t_colors    rows;
} t_column_pixels;

class render_scoreboard;
    logic [7:0]     levels [SAMPLE_COUNT];
    bit             has_data;
    logic [1:0]     mode;
    logic [1:0]     style;
    bit             bars;
    bit             smooth;
    t_column_pixels expected_columns [$];
    int             errors;
    int             writes_noted;
    int             clears_noted;
    int             renders_noted;
    int             columns_checked;

    function new();
        foreach (levels[i]) levels[i] = 8'd0;
        has_data = 1'b0;
        mode     = MODE_ANALYZER;
        style    = STYLE_DOT;
        bars     = 1'b0;
        smooth   = 1'b0;
    endfunction

    task report(input string what);
        // Past a few dozen lines only the count goes on.
        if (errors < 40) $display("[%0t] ERROR: %s", $time, what);
        errors++;
    endtask

    function void set_register(input logic [1:0] index, input logic [1:0] value);
        case (index)
            REG_DISPLAY_MODE: mode = value;
            REG_BAR_LAYOUT:   bars = value[0];
            REG_SMOOTH_METER: smooth = value[0];
            REG_SCOPE_STYLE:  style = value;
            default: ;
        endcase
    endfunction

    function int unsigned trace_row(input int unsigned idx);
        int unsigned v;
        v = (idx < SAMPLE_COUNT) ? levels[idx] : 0;
        if (v > 16) v = 16;
        return TRACE_ROW_OF_LEVEL[v];
    endfunction

    function t_colors fill_rows(input t_colors px, input int unsigned lo,
                                input int unsigned hi);
        int unsigned y;
        for (y = lo; y <= hi && y < ROWS; y++) px[y] = TRACE_SHADES[y];
        return px;
    endfunction

    function t_colors paint_column(input int unsigned c);
        t_colors     px;
        int unsigned y, idx, h, h2, d, t;
        px = '0;
        if (c >= COLUMNS) return px;
        case (mode)
            MODE_ANALYZER: begin
                // In bar mode every third column is the gap between bars.
                if (bars && c % 3 == 2) return px;
                idx = bars ? c / 3 : c;
                h = (levels[idx] > 5) ? 5 : levels[idx];
                for (y = ROWS - h; y < ROWS; y++) px[y] = BAR_SHADES[ROWS - 1 - y];
            end
            MODE_VU: begin
                // Rows 0 and 1 follow the first level, rows 3 and 4 the second.
                for (y = 0; y < ROWS; y++) begin
                    if (y != 2) begin
                        d = levels[y / 3];
                        if (smooth) begin
                            h = (d > COLUMNS) ? COLUMNS : d;
                            if (c < h) px[y] = 5'(17 - (c * 16) / COLUMNS);
                        end else begin
                            h = (d * 8 + 19) / COLUMNS;
                            if (h > 8) h = 8;
                            if (c % 5 < 3 && c / 5 < h) px[y] = METER_SHADES[(c / 5) % 8];
                        end
                    end
                end
            end
            MODE_SCOPE: begin
                if (!has_data) return px;
                h = trace_row(2 * c);
                case (style)
                    STYLE_DOT: px[h] = TRACE_SHADES[h];
                    STYLE_LINE: begin
                        if (c + 1 >= COLUMNS) begin
                            px[h] = TRACE_SHADES[h];
                        end else begin
                            // Join this sample to the next one with a vertical run.
                            h2 = trace_row(2 * c + 2);
                            if (h < h2) begin
                                h2--;
                            end else if (h > h2) begin
                                t  = h;
                                h  = h2 + 1;
                                h2 = t;
                            end
                            px = fill_rows(px, h, h2);
                        end
                    end
                    default: px = (h < 2) ? fill_rows(px, h, 2) : fill_rows(px, 2, h);
                endcase
            end
            default: ;
        endcase
        return px;
    endfunction

    function void note_input(input logic [1:0] op, input logic [6:0] idx,
                             input logic [7:0] lvl, input logic [5:0] col);
        t_column_pixels want;
        case (op)
            OP_WRITE: begin
                writes_noted++;
                if (idx < SAMPLE_COUNT) begin
                    levels[idx] = lvl;
                    has_data    = 1'b1;
                end
            end
            OP_CLEAR: begin
                clears_noted++;
                foreach (levels[i]) levels[i] = 8'd0;
                has_data = 1'b0;
            end
            OP_RENDER: begin
                renders_noted++;
                want.column = col;
                want.rows   = paint_column(col);
                expected_columns.push_back(want);
            end
            default: ;
        endcase
    endfunction

    task check_result(input logic [5:0] col, input t_colors got);
        t_column_pixels want;
        int             y;
        if (expected_columns.size() == 0) begin
            report($sformatf("result for column %0d with no render pending", col));
            return;
        end
        want = expected_columns.pop_front();
        columns_checked++;
        if (col !== want.column)
            report($sformatf("column field %0d, expected %0d", col, want.column));
        for (y = 0; y < ROWS; y++) begin
            if (got[y] !== want.rows[y])
                report($sformatf("column %0d row %0d: color %0d, expected %0d",
                                 want.column, y, got[y], want.rows[y]));
        end
    endtask

    task check_drained();
        if (expected_columns.size() != 0)
            report($sformatf("%0d rendered columns never came out", expected_columns.size()));
    endtask
endclass

module testbench;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 55;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [1:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [1:0] i_op;
    logic [6:0] i_sample_index;
    logic [7:0] i_sample_value;
    logic [5:0] i_column;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [5:0] o_out_column;
    logic [4:0] o_row0_color;
    logic [4:0] o_row1_color;
    logic [4:0] o_row2_color;
    logic [4:0] o_row3_color;
    logic [4:0] o_row4_color;

    render_scoreboard board = new();
    bit               calm = 1'b0;
    int               quiet_cycles = 0;

    mini_vis_column_renderer_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_sample_index (i_sample_index),
        .i_sample_value (i_sample_value),
        .i_column       (i_column),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_column   (o_out_column),
        .o_row0_color   (o_row0_color),
        .o_row1_color   (o_row1_color),
        .o_row2_color   (o_row2_color),
        .o_row3_color   (o_row3_color),
        .o_row4_color   (o_row4_color)
    );

    always #1 i_clk = ~i_clk;

    // Mostly no pause, sometimes a short one, rarely a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Both channels and the register port are observed here, at the rising edge.
    always @(posedge i_clk) begin
        t_colors got;
        if (i_rst_n) begin
            if (i_cfg_we) board.set_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                board.note_input(i_op, i_sample_index, i_sample_value, i_column);
            if (o_out_valid && i_out_ready) begin
                got[0] = o_row0_color;
                got[1] = o_row1_color;
                got[2] = o_row2_color;
                got[3] = o_row3_color;
                got[4] = o_row4_color;
                board.check_result(o_out_column, got);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready)
                || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            board.report($sformatf("no transaction for %0d cycles", STALL_LIMIT));
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Output back-pressure: runs of ready broken by stalls of random length.
    initial begin
        int hold;
        hold = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                i_out_ready = 1'b1;
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else if (i_out_ready) begin
                i_out_ready = 1'b0;
                hold = idle_len();
            end else begin
                i_out_ready = 1'b1;
                hold = $urandom_range(0, 8);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [1:0] op, input logic [6:0] idx,
                             input logic [7:0] lvl, input logic [5:0] col);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op           = op;
        i_sample_index = idx;
        i_sample_value = lvl;
        i_column       = col;
        i_in_valid     = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Registers change only once every rendered column is out and the pipeline is empty.
    task automatic configure(input logic [1:0] mode, input logic [1:0] bars,
                             input logic [1:0] smooth, input logic [1:0] style);
        i_in_valid = 1'b0;
        while (board.expected_columns.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = REG_DISPLAY_MODE;
        i_cfg_data  = mode;
        @(negedge i_clk);
        i_cfg_index = REG_BAR_LAYOUT;
        i_cfg_data  = bars;
        @(negedge i_clk);
        i_cfg_index = REG_SMOOTH_METER;
        i_cfg_data  = smooth;
        @(negedge i_clk);
        i_cfg_index = REG_SCOPE_STYLE;
        i_cfg_data  = style;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Indexes lean toward the entries that the modes read most; levels toward
    // the small values where the height tables change.
    task automatic random_item();
        int         r;
        logic [1:0] op;
        logic [6:0] idx;
        logic [7:0] lvl;
        logic [5:0] col;
        r  = $urandom_range(0, 99);
        op = (r < 38) ? OP_WRITE : (r < 41) ? OP_CLEAR : (r < 96) ? OP_RENDER : OP_SPARE;
        r  = $urandom_range(0, 19);
        if (r < 5)       idx = 7'($urandom_range(0, 1));
        else if (r < 9)  idx = 7'($urandom_range(0, 12));
        else if (r < 19) idx = 7'($urandom_range(0, SAMPLE_COUNT - 1));
        else             idx = 7'($urandom_range(SAMPLE_COUNT, 127));
        r = $urandom_range(0, 9);
        if (r < 4)      lvl = 8'($urandom_range(0, 20));
        else if (r < 6) lvl = 8'($urandom_range(0, 45));
        else            lvl = 8'($urandom);
        if ($urandom_range(0, 19) == 0) col = 6'($urandom_range(COLUMNS, 63));
        else                            col = 6'($urandom_range(0, COLUMNS - 1));
        send_item(op, idx, lvl, col);
    endtask

    initial begin
        int         phase;
        logic [1:0] mode;
        logic [1:0] style;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = REG_DISPLAY_MODE;
        i_cfg_data     = 2'd0;
        i_in_valid     = 1'b0;
        i_op           = OP_WRITE;
        i_sample_index = 7'd0;
        i_sample_value = 8'd0;
        i_column       = 6'd0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset settings, empty store, out-of-range fields and the spare opcode.
        send_item(OP_RENDER, 7'd0, 8'd0, 6'd0);
        send_item(OP_RENDER, 7'd127, 8'd255, 6'd63);
        send_item(OP_WRITE, 7'd75, 8'd9, 6'd0);
        send_item(OP_WRITE, 7'd127, 8'd255, 6'd0);
        send_item(OP_SPARE, 7'd3, 8'd3, 6'd3);
        // The ignored writes must not have made the scope active.
        configure(MODE_SCOPE, 2'd0, 2'd0, STYLE_DOT);
        send_item(OP_RENDER, 7'd0, 8'd0, 6'd10);
        send_item(OP_WRITE, 7'd0, 8'd255, 6'd0);
        send_item(OP_WRITE, 7'd74, 8'd16, 6'd0);
        send_item(OP_WRITE, 7'd2, 8'd7, 6'd0);
        send_item(OP_WRITE, 7'd1, 8'd38, 6'd0);
        send_item(OP_RENDER, 7'd0, 8'd0, 6'd0);
        send_item(OP_RENDER, 7'd0, 8'd0, 6'd37);
        configure(MODE_SCOPE, 2'd0, 2'd0, STYLE_LINE);
        send_item(OP_RENDER, 7'd0, 8'd0, 6'd0);
        send_item(OP_RENDER, 7'd0, 8'd0, 6'd37);
        configure(MODE_SCOPE, 2'd0, 2'd0, STYLE_SPARE);
        send_item(OP_RENDER, 7'd0, 8'd0, 6'd1);
        send_item(OP_CLEAR, 7'd0, 8'd0, 6'd0);
        send_item(OP_RENDER, 7'd0, 8'd0, 6'd0);
        configure(MODE_VU, 2'd0, 2'd0, STYLE_DOT);
        send_item(OP_WRITE, 7'd0, 8'd255, 6'd0);
        send_item(OP_WRITE, 7'd1, 8'd37, 6'd0);
        send_item(OP_RENDER, 7'd0, 8'd0, 6'd0);
        send_item(OP_RENDER, 7'd0, 8'd0, 6'd37);
        configure(MODE_VU, 2'd0, 2'd1, STYLE_DOT);
        send_item(OP_RENDER, 7'd0, 8'd0, 6'd36);
        configure(MODE_OFF, 2'd0, 2'd0, STYLE_DOT);
        send_item(OP_RENDER, 7'd0, 8'd0, 6'd5);
        configure(MODE_ANALYZER, 2'd1, 2'd0, STYLE_DOT);
        send_item(OP_WRITE, 7'd12, 8'd5, 6'd0);
        send_item(OP_RENDER, 7'd0, 8'd0, 6'd37);
        send_item(OP_RENDER, 7'd0, 8'd0, 6'd2);

        // One phase per drawing style, then phases with fully random settings.
        // The upper data bit of the one-bit registers is random throughout.
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < 2)       mode = MODE_ANALYZER;
            else if (phase < 4)  mode = MODE_VU;
            else if (phase < 8)  mode = MODE_SCOPE;
            else if (phase == 8) mode = MODE_OFF;
            else                 mode = 2'($urandom);
            style = (phase >= 4 && phase < 8) ? 2'(phase - 4) : 2'($urandom);
            if (phase < 9)
                configure(mode, {1'($urandom), phase == 1}, {1'($urandom), phase == 3}, style);
            else
                configure(mode, 2'($urandom), 2'($urandom), style);
            calm = (phase == 2 || phase == 6);
            repeat (PHASE_ITEMS) random_item();
        end
        calm = 1'b0;

        i_in_valid = 1'b0;
        while (board.expected_columns.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        board.check_drained();

        $display("Covered %0d sample writes, %0d clears and %0d column renders",
                 board.writes_noted, board.clears_noted, board.renders_noted);
        $display("over %0d setting phases; %0d columns compared, %0d mismatches.",
                 PHASES, board.columns_checked, board.errors);
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[mini_vis_column_renderer_top.f]
sv/mvcr_pkg.sv
sv/mvcr_store.sv
sv/mvcr_pixel.sv
sv/mini_vis_column_renderer_top.sv
sv/mvcr_checker.sv
tb/testbench.sv
